/* hdl/rbs_pkg.sv */
// ----------------------------------------------------------------------------
// rbs_pkg
// Shared types and constants of the ray versus box slab intersection block.
// ----------------------------------------------------------------------------
package rbs_pkg;

  localparam int unsigned NumAxes         = 3;
  localparam int unsigned CfgIdxW         = 4;
  localparam int unsigned QuotW           = 32;
  localparam int unsigned DivStepsPerStage = 4;
  localparam int unsigned DivStages       = QuotW / DivStepsPerStage;
  // One load stage in front of the quotient stages.
  localparam int unsigned DivLat          = DivStages + 1;

  typedef enum logic [CfgIdxW-1:0] {
    REG_BOX_MIN_X   = 4'd0,
    REG_BOX_MAX_X   = 4'd1,
    REG_BOX_MIN_Y   = 4'd2,
    REG_BOX_MAX_Y   = 4'd3,
    REG_BOX_MIN_Z   = 4'd4,
    REG_BOX_MAX_Z   = 4'd5,
    REG_INVERSE_BOX = 4'd6,
    REG_EPSILON     = 4'd7
  } cfg_reg_e;

  typedef struct packed {
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
    logic signed [31:0] window_near;
    logic signed [31:0] window_far;
  } ray_t;

  typedef struct packed {
    logic [1:0]         hit_count;
    logic signed [31:0] first_distance;
    logic               first_entering;
    logic signed [31:0] second_distance;
    logic               second_entering;
  } hit_t;

  typedef struct packed {
    logic [32:0] mag_lo;
    logic [32:0] mag_hi;
    logic [31:0] den;
    logic        neg_lo;
    logic        neg_hi;
    logic        par;
    logic        in_slab;
  } front_ax_t;

  typedef struct packed {
    logic neg_lo;
    logic neg_hi;
    logic par;
    logic in_slab;
  } side_ax_t;

  typedef struct packed {
    side_ax_t [NumAxes-1:0] ax;
    logic signed [31:0]     wn;
    logic signed [31:0]     wf;
  } side_t;

endpackage

/* hdl/rbs_if.sv */
// ----------------------------------------------------------------------------
// rbs channel interfaces
// Valid/ready channels for rays, hit results and configuration writes.
// ----------------------------------------------------------------------------
interface rbs_ray_if;
  logic          valid;
  logic          ready;
  rbs_pkg::ray_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rbs_hit_if;
  logic          valid;
  logic          ready;
  rbs_pkg::hit_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rbs_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [rbs_pkg::CfgIdxW-1:0] index;
  logic [31:0]                 data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

/* hdl/rbs_front.sv */
// ----------------------------------------------------------------------------
// rbs_front
// Per axis plane offsets and magnitudes, |dir|, parallel and in-slab tests.
// ----------------------------------------------------------------------------
module rbs_front (
  input  rbs_pkg::ray_t                                ray_i,
  input  logic [rbs_pkg::NumAxes-1:0][31:0]            box_min_i,
  input  logic [rbs_pkg::NumAxes-1:0][31:0]            box_max_i,
  input  logic [15:0]                                  eps_i,
  output rbs_pkg::front_ax_t [rbs_pkg::NumAxes-1:0]    ax_o
);

  logic [rbs_pkg::NumAxes-1:0][31:0] org;
  logic [rbs_pkg::NumAxes-1:0][31:0] dir;

  assign org = {ray_i.origin_z, ray_i.origin_y, ray_i.origin_x};
  assign dir = {ray_i.dir_z, ray_i.dir_y, ray_i.dir_x};

  always_comb begin
    logic signed [32:0] num_lo;
    logic signed [32:0] num_hi;
    logic [32:0]        dneg;
    logic [31:0]        ad;
    for (int a = 0; a < rbs_pkg::NumAxes; a++) begin
      num_lo = $signed({box_min_i[a][31], box_min_i[a]}) - $signed({org[a][31], org[a]});
      num_hi = $signed({box_max_i[a][31], box_max_i[a]}) - $signed({org[a][31], org[a]});
      dneg   = 33'd0 - {dir[a][31], dir[a]};
      ad     = dir[a][31] ? dneg[31:0] : dir[a];
      ax_o[a].mag_lo = num_lo[32] ? 33'(-num_lo) : 33'(num_lo);
      ax_o[a].mag_hi = num_hi[32] ? 33'(-num_hi) : 33'(num_hi);
      ax_o[a].den    = ad;
      ax_o[a].neg_lo = num_lo[32] ^ dir[a][31];
      ax_o[a].neg_hi = num_hi[32] ^ dir[a][31];
      ax_o[a].par    = ad <= {16'd0, eps_i};
      ax_o[a].in_slab = !(($signed(org[a]) < $signed(box_min_i[a])) ||
                          ($signed(org[a]) > $signed(box_max_i[a])));
    end
  end

endmodule

/* hdl/rbs_div.sv */
// ----------------------------------------------------------------------------
// rbs_div
// Pipelined restoring divider for (mag << 16) / den, several bits per stage.
// ----------------------------------------------------------------------------
module rbs_div (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [32:0]                  mag_i,
  input  logic [31:0]                  den_i,
  output logic [rbs_pkg::QuotW-1:0]    quot_o,
  output logic                         ovf_o
);

  localparam int unsigned NS = rbs_pkg::DivStages;

  logic [31:0]               rem_q  [NS+1];
  logic [31:0]               num_q  [NS+1];
  logic [31:0]               den_q  [NS+1];
  logic [rbs_pkg::QuotW-1:0] quot_q [NS+1];
  logic                      ovf_q  [NS+1];

  // The quotient fits 32 bits unless mag >= den << 16; that case sets ovf_o.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= {15'd0, mag_i[32:16]};
      num_q[0]  <= {mag_i[15:0], 16'd0};
      den_q[0]  <= den_i;
      quot_q[0] <= '0;
      ovf_q[0]  <= {15'd0, mag_i} >= {den_i, 16'd0};
    end
  end

  for (genvar s = 0; s < NS; s++) begin : g_stage
    logic [31:0]               rem_d;
    logic [31:0]               num_d;
    logic [rbs_pkg::QuotW-1:0] quot_d;

    always_comb begin
      logic [32:0] trial;
      rem_d  = rem_q[s];
      num_d  = num_q[s];
      quot_d = quot_q[s];
      for (int k = 0; k < rbs_pkg::DivStepsPerStage; k++) begin
        trial = {rem_d, num_d[31]};
        num_d = {num_d[30:0], 1'b0};
        if (trial >= {1'b0, den_q[s]}) begin
          trial  = trial - {1'b0, den_q[s]};
          quot_d = {quot_d[rbs_pkg::QuotW-2:0], 1'b1};
        end else begin
          quot_d = {quot_d[rbs_pkg::QuotW-2:0], 1'b0};
        end
        rem_d = trial[31:0];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s+1]  <= rem_d;
        num_q[s+1]  <= num_d;
        den_q[s+1]  <= den_q[s];
        quot_q[s+1] <= quot_d;
        ovf_q[s+1]  <= ovf_q[s];
      end
    end
  end

  assign quot_o = quot_q[NS];
  assign ovf_o  = ovf_q[NS];

endmodule

/* hdl/rbs_back.sv */
// ----------------------------------------------------------------------------
// rbs_back
// Saturation, per axis slab intervals, interval merge and hit selection.
// ----------------------------------------------------------------------------
module rbs_back (
  input  logic                                   clk_i,
  input  logic                                   en_i,
  input  logic [2*rbs_pkg::NumAxes-1:0][31:0]    quot_i,
  input  logic [2*rbs_pkg::NumAxes-1:0]          ovf_i,
  input  rbs_pkg::side_t                         side_i,
  input  logic [15:0]                            eps_i,
  input  logic                                   inverse_i,
  output rbs_pkg::hit_t                          hit_o
);

  localparam logic signed [33:0] Unb = 34'sh1_0000_0000;

  logic [rbs_pkg::NumAxes-1:0]              ok_d, ok_q;
  logic signed [rbs_pkg::NumAxes-1:0][33:0] lo_d, lo_q, hi_d, hi_q;
  logic signed [31:0]                       wn_q, wf_q, wn2_q, wf2_q;
  logic signed [33:0]                       near_q, far_q, near_d, far_d;
  logic                                     all_ok_q;

  function automatic logic signed [33:0] sat_quot(logic [31:0] q, logic ovf, logic neg);
    logic [32:0] mag;
    logic [32:0] val;
    if (neg) begin
      mag = (ovf || (q > 32'h8000_0000)) ? 33'h0_8000_0000 : {1'b0, q};
      val = 33'd0 - mag;
    end else begin
      val = (ovf || q[31]) ? 33'h0_7FFF_FFFF : {1'b0, q};
    end
    return 34'($signed({val[31], val[31:0]}));
  endfunction

  always_comb begin
    logic signed [33:0] t1;
    logic signed [33:0] t2;
    logic signed [33:0] e;
    e = $signed({18'd0, eps_i});
    for (int a = 0; a < rbs_pkg::NumAxes; a++) begin
      t1 = sat_quot(quot_i[2*a], ovf_i[2*a], side_i.ax[a].neg_lo);
      t2 = sat_quot(quot_i[2*a+1], ovf_i[2*a+1], side_i.ax[a].neg_hi);
      if (side_i.ax[a].par) begin
        ok_d[a] = side_i.ax[a].in_slab;
        lo_d[a] = -Unb;
        hi_d[a] = Unb;
      end else begin
        ok_d[a] = !((t1 < e) && (t2 < e));
        lo_d[a] = (t1 < t2) ? t1 : t2;
        hi_d[a] = (t1 < t2) ? t2 : t1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ok_q <= ok_d;
      lo_q <= lo_d;
      hi_q <= hi_d;
      wn_q <= side_i.wn;
      wf_q <= side_i.wf;
    end
  end

  // Elements of a packed array select as unsigned, so they are compared as signed here.
  always_comb begin
    near_d = -Unb;
    far_d  = Unb;
    for (int a = 0; a < rbs_pkg::NumAxes; a++) begin
      if ($signed(lo_q[a]) > near_d) begin
        near_d = lo_q[a];
      end
      if ($signed(hi_q[a]) < far_d) begin
        far_d = hi_q[a];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      near_q   <= near_d;
      far_q    <= far_d;
      all_ok_q <= &ok_q;
      wn2_q    <= wn_q;
      wf2_q    <= wf_q;
    end
  end

  always_comb begin
    logic signed [33:0] wn;
    logic signed [33:0] wf;
    wn    = 34'(wn2_q);
    wf    = 34'(wf2_q);
    hit_o = '0;
    if (all_ok_q && (near_q < far_q) && (far_q > wn) && (near_q < wf)) begin
      if (near_q > wn) begin
        hit_o.hit_count      = 2'd1;
        hit_o.first_distance = near_q[31:0];
        hit_o.first_entering = !inverse_i;
        if (far_q < wf) begin
          hit_o.hit_count       = 2'd2;
          hit_o.second_distance = far_q[31:0];
          hit_o.second_entering = inverse_i;
        end
      end else if (far_q < wf) begin
        hit_o.hit_count      = 2'd1;
        hit_o.first_distance = far_q[31:0];
        hit_o.first_entering = inverse_i;
      end
    end
  end

endmodule

/* hdl/ray_box_slab_intersect_top.sv */
// ----------------------------------------------------------------------------
// ray_box_slab_intersect_top
// Ray versus axis-aligned box intersection, slab method, fully pipelined.
// ----------------------------------------------------------------------------
// Accepts one ray per clock and returns one result transaction per ray, in
// order. A ray passes through the ray register, the front register, the six
// plane-distance dividers, each a load stage followed by eight stages
// resolving four quotient bits per stage, the two back registers and the
// output register.
// The whole pipeline advances together; it holds while the output register
// is full and not taken.
// Configuration writes must be made only while no ray is in flight.
module ray_box_slab_intersect_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  rbs_cfg_if.sink       cfg_i,
  rbs_ray_if.sink       ray_i,
  rbs_hit_if.source     hit_o
);

  localparam int unsigned NA   = rbs_pkg::NumAxes;
  localparam int unsigned DL   = rbs_pkg::DivLat;
  // ray reg, front reg, divider, two back stages, output reg
  localparam int unsigned NV   = DL + 5;

  logic [NA-1:0][31:0] box_min_q, box_max_q;
  logic                inverse_q;
  logic [15:0]         eps_q;

  logic [NV-1:0]       vld_q;
  logic                adv;

  rbs_pkg::ray_t                  ray_q;
  rbs_pkg::front_ax_t [NA-1:0]    front_d, front_q;
  rbs_pkg::side_t                 side_q [DL+1];
  rbs_pkg::side_t                 side_d;
  logic [2*NA-1:0][31:0]          quot;
  logic [2*NA-1:0]                ovf;
  rbs_pkg::hit_t                  hit_d, hit_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_min_q <= {NA{32'hFFFF_0000}};
      box_max_q <= {NA{32'h0001_0000}};
      inverse_q <= 1'b0;
      eps_q     <= 16'd7;
    end else if (cfg_i.valid) begin
      unique case (rbs_pkg::cfg_reg_e'(cfg_i.index))
        rbs_pkg::REG_BOX_MIN_X:   box_min_q[0] <= cfg_i.data;
        rbs_pkg::REG_BOX_MAX_X:   box_max_q[0] <= cfg_i.data;
        rbs_pkg::REG_BOX_MIN_Y:   box_min_q[1] <= cfg_i.data;
        rbs_pkg::REG_BOX_MAX_Y:   box_max_q[1] <= cfg_i.data;
        rbs_pkg::REG_BOX_MIN_Z:   box_min_q[2] <= cfg_i.data;
        rbs_pkg::REG_BOX_MAX_Z:   box_max_q[2] <= cfg_i.data;
        rbs_pkg::REG_INVERSE_BOX: inverse_q    <= cfg_i.data[0];
        rbs_pkg::REG_EPSILON:     eps_q        <= cfg_i.data[15:0];
        default: ;
      endcase
    end
  end

  // Every stage moves when the output register is empty or being drained.
  assign adv         = !vld_q[NV-1] || hit_o.ready;
  assign ray_i.ready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NV-2:0], ray_i.valid};
    end
  end

  rbs_front u_front (
    .ray_i     (ray_q),
    .box_min_i (box_min_q),
    .box_max_i (box_max_q),
    .eps_i     (eps_q),
    .ax_o      (front_d)
  );

  always_comb begin
    for (int a = 0; a < NA; a++) begin
      side_d.ax[a].neg_lo  = front_d[a].neg_lo;
      side_d.ax[a].neg_hi  = front_d[a].neg_hi;
      side_d.ax[a].par     = front_d[a].par;
      side_d.ax[a].in_slab = front_d[a].in_slab;
    end
    side_d.wn = ray_q.window_near;
    side_d.wf = ray_q.window_far;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ray_q     <= ray_i.data;
      front_q   <= front_d;
      side_q[0] <= side_d;
      for (int s = 1; s <= DL; s++) begin
        side_q[s] <= side_q[s-1];
      end
      hit_q     <= hit_d;
    end
  end

  for (genvar a = 0; a < NA; a++) begin : g_axis
    rbs_div u_div_lo (
      .clk_i  (clk_i),
      .en_i   (adv),
      .mag_i  (front_q[a].mag_lo),
      .den_i  (front_q[a].den),
      .quot_o (quot[2*a]),
      .ovf_o  (ovf[2*a])
    );
    rbs_div u_div_hi (
      .clk_i  (clk_i),
      .en_i   (adv),
      .mag_i  (front_q[a].mag_hi),
      .den_i  (front_q[a].den),
      .quot_o (quot[2*a+1]),
      .ovf_o  (ovf[2*a+1])
    );
  end

  // The side data must line up with the divider outputs, DL stages after front_q.
  rbs_back u_back (
    .clk_i     (clk_i),
    .en_i      (adv),
    .quot_i    (quot),
    .ovf_i     (ovf),
    .side_i    (side_q[DL]),
    .eps_i     (eps_q),
    .inverse_i (inverse_q),
    .hit_o     (hit_d)
  );

  assign hit_o.valid = vld_q[NV-1];
  assign hit_o.data  = hit_q;

`ifndef SYNTH
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit_o.valid |-> (hit_q.hit_count != 2'd3))
    else $error("hit count out of range");

  a_unused_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hit_o.valid && (hit_q.hit_count == 2'd0)) |->
      ((hit_q.first_distance == '0) && !hit_q.first_entering &&
       (hit_q.second_distance == '0) && !hit_q.second_entering))
    else $error("unused hit fields not cleared");

  a_hit_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hit_o.valid && (hit_q.hit_count == 2'd2)) |->
      ((hit_q.first_distance < hit_q.second_distance) &&
       (hit_q.first_entering != hit_q.second_entering)))
    else $error("two hits out of order");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hit_o.valid && !hit_o.ready) |=> (hit_o.valid && $stable(hit_q)))
    else $error("stalled result changed");
`endif

endmodule
